[src/dst_pkg.sv]
// ----------------------------------------------------------------------------
// dst_pkg: shared types and constants for the digit/symbol tokenizer
// Token layout, token kinds, character codes and the operator symbol set.
// ----------------------------------------------------------------------------
package dst_pkg;

    localparam int TOKEN_VALUE_WIDTH = 32;
    localparam int TOKEN_COORD_WIDTH = 16;
    localparam int SYMBOL_COUNT      = 17;

    typedef enum logic [1:0] {
        KIND_NUMBER = 2'd0,
        KIND_SYMBOL = 2'd1,
        KIND_ERROR  = 2'd2
    } token_kind_t;

    typedef struct packed {
        token_kind_t                   kind;
        logic [TOKEN_VALUE_WIDTH-1:0]  value;
        logic [TOKEN_COORD_WIDTH-1:0]  column;
        logic [TOKEN_COORD_WIDTH-1:0]  line;
        logic                          last;
    } token_t;

    // Tokens produced by one byte: count is 0, 1 or 2, tok0 goes out first.
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } scan_result_t;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // ~ ! @ # $ % ^ & * ( ) - = + / [ ]
    localparam logic [7:0] SYMBOL_SET [SYMBOL_COUNT] = '{
        8'h7E, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h2D, 8'h3D, 8'h2B, 8'h2F, 8'h5B, 8'h5D
    };

    function automatic logic is_symbol(input logic [7:0] ch);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < SYMBOL_COUNT; i++)
        begin
            if (SYMBOL_SET[i] == ch)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

[src/dst_scan.sv]
// ----------------------------------------------------------------------------
// dst_scan: scanner state and per-byte token logic
// Classifies one byte, updates accumulator and coordinates, forms up to two
// tokens for that byte.
// ----------------------------------------------------------------------------
module dst_scan #(
    parameter int VALUE_WIDTH = 32,
    parameter int COORD_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            char_code,
    input  logic                  end_of_text,
    output dst_pkg::scan_result_t result
);

    logic [VALUE_WIDTH-1:0] accum_reg,       accum_next;
    logic                   have_digits_reg, have_digits_next;
    logic [COORD_WIDTH-1:0] column_reg,      column_next;
    logic [COORD_WIDTH-1:0] line_reg,        line_next;
    logic                   failed_reg,      failed_next;

    logic                   is_sym, is_digit, is_space, is_newline;
    logic [COORD_WIDTH-1:0] col_new, line_new;
    logic [VALUE_WIDTH-1:0] accum_new;
    logic                   have_new, failed_new;

    logic [VALUE_WIDTH+3:0] accum_wide, digit_ext, accum_x10;
    logic [VALUE_WIDTH+31:0] pend_ext, flush_ext;
    logic [COORD_WIDTH+15:0] col_ext, line_ext;

    dst_pkg::token_t num_tok, flush_tok, char_tok;

    assign is_sym     = dst_pkg::is_symbol(char_code);
    assign is_digit   = (char_code >= dst_pkg::CHAR_ZERO) && (char_code <= dst_pkg::CHAR_NINE);
    assign is_space   = (char_code == dst_pkg::CHAR_SPACE);
    assign is_newline = (char_code == dst_pkg::CHAR_NEWLINE);

    // accum * 10 + digit; saturate when anything lands above VALUE_WIDTH bits
    assign accum_wide = {4'b0000, accum_reg};
    assign digit_ext  = {{VALUE_WIDTH{1'b0}}, char_code[3:0]};
    assign accum_x10  = (accum_wide << 3) + (accum_wide << 1) + digit_ext;

    always_comb
    begin
        accum_new  = accum_reg;
        have_new   = have_digits_reg;
        failed_new = failed_reg;
        col_new    = column_reg;
        line_new   = line_reg;

        if (!failed_reg)
        begin
            if (is_newline)
            begin
                col_new = '0;
                if (!(&line_reg))
                begin
                    line_new = line_reg + 1'b1;
                end
            end
            else if (!(&column_reg))
            begin
                col_new = column_reg + 1'b1;
            end

            priority if (is_sym || is_space)
            begin
                accum_new = '0;
                have_new  = 1'b0;
            end
            else if (is_digit)
            begin
                accum_new = (|accum_x10[VALUE_WIDTH+3:VALUE_WIDTH]) ?
                            {VALUE_WIDTH{1'b1}} : accum_x10[VALUE_WIDTH-1:0];
                have_new  = 1'b1;
            end
            else if (is_newline)
            begin
                accum_new = accum_reg;
            end
            else
            begin
                accum_new  = '0;
                have_new   = 1'b0;
                failed_new = 1'b1;
            end
        end
    end

    // Fit internal widths onto the fixed token fields
    assign pend_ext  = {32'd0, accum_reg};
    assign flush_ext = {32'd0, accum_new};
    assign col_ext   = {16'd0, col_new};
    assign line_ext  = {16'd0, line_new};

    always_comb
    begin
        num_tok.kind     = dst_pkg::KIND_NUMBER;
        num_tok.value    = pend_ext[31:0];
        num_tok.column   = col_ext[15:0];
        num_tok.line     = line_ext[15:0];
        num_tok.last     = 1'b0;

        flush_tok        = num_tok;
        flush_tok.value  = flush_ext[31:0];
        flush_tok.last   = 1'b1;

        char_tok         = num_tok;
        char_tok.kind    = is_sym ? dst_pkg::KIND_SYMBOL : dst_pkg::KIND_ERROR;
        char_tok.value   = {24'd0, char_code};

        result = '0;
        if (!failed_reg)
        begin
            if (is_sym)
            begin
                if (have_digits_reg)
                begin
                    result.count = 2'd2;
                    result.tok0  = num_tok;
                    result.tok1  = char_tok;
                    result.tok1.last = 1'b1;
                end
                else
                begin
                    result.count = 2'd1;
                    result.tok0  = char_tok;
                    result.tok0.last = 1'b1;
                end
            end
            else if (failed_new)
            begin
                result.count = 2'd1;
                result.tok0  = char_tok;
                result.tok0.last = 1'b1;
            end
            else if (end_of_text && have_new)
            begin
                result.count = 2'd1;
                result.tok0  = flush_tok;
            end
        end
    end

    always_comb
    begin
        if (end_of_text)
        begin
            accum_next       = '0;
            have_digits_next = 1'b0;
            column_next      = '0;
            line_next        = '0;
            failed_next      = 1'b0;
        end
        else
        begin
            accum_next       = accum_new;
            have_digits_next = have_new;
            column_next      = col_new;
            line_next        = line_new;
            failed_next      = failed_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg       <= '0;
            have_digits_reg <= 1'b0;
            column_reg      <= '0;
            line_reg        <= '0;
            failed_reg      <= 1'b0;
        end
        else if (step)
        begin
            accum_reg       <= accum_next;
            have_digits_reg <= have_digits_next;
            column_reg      <= column_next;
            line_reg        <= line_next;
            failed_reg      <= failed_next;
        end
    end

    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && end_of_text) |=> (!failed_reg && !have_digits_reg && accum_reg == '0
                                   && column_reg == '0 && line_reg == '0))
        else $error("state not cleared after end of text");

    a_muted: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> (result.count == 2'd0))
        else $error("token produced while muted");

    a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !have_digits_reg |-> (accum_reg == '0))
        else $error("accumulator holds value without pending digits");

    a_pair_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.count == 2'd2) |=> !have_digits_reg)
        else $error("pending number kept after symbol flush");

endmodule

[src/dst_obuf.sv]
// ----------------------------------------------------------------------------
// dst_obuf: two-entry token output buffer
// Holds the tokens of one byte and presents them one transfer at a time.
// ----------------------------------------------------------------------------
module dst_obuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  dst_pkg::scan_result_t result,
    input  logic                  ready,
    output logic                  valid,
    output dst_pkg::token_t       head,
    output logic                  can_load
);

    logic [1:0]      count_reg, count_next;
    dst_pkg::token_t slot0_reg, slot0_next;
    dst_pkg::token_t slot1_reg, slot1_next;
    logic            pop;

    assign valid    = (count_reg != 2'd0);
    assign head     = slot0_reg;
    assign pop      = valid && ready;
    // buffer is empty by the end of this cycle
    assign can_load = (count_reg == 2'd0) || ((count_reg == 2'd1) && ready);

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load && result.count != 2'd0)
        begin
            count_next = result.count;
            slot0_next = result.tok0;
            slot1_next = result.tok1;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    a_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
        ((count_reg == 2'd1) |-> slot0_reg.last)
        and ((count_reg == 2'd2) |-> (!slot0_reg.last && slot1_reg.last)))
        else $error("tlast misplaced in output buffer");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && result.count != 2'd0) |-> can_load)
        else $error("tokens loaded over undelivered tokens");

endmodule

[src/digit_symbol_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// digit_symbol_tokenizer_core: byte-stream scanner for numbers and symbols
// Turns a text byte stream into number, symbol and error tokens.
// ----------------------------------------------------------------------------
// One text byte per slave transfer, s_tlast on the final byte of a text.
// Decimal digits build a number (saturating at VALUE_WIDTH bits); one of the
// 17 operator symbols ~!@#$%^&*()-=+/[] emits the pending number, if any, then
// a symbol token; a space drops pending digits; a newline zeroes the column
// and bumps the line. Any other byte yields an error token and mutes the
// scanner until the end of text. The final byte flushes the pending number and
// returns all state to reset. Each token leaves as one master transfer with
// its column and line; m_tlast marks the last token caused by a byte.
// Rate: one byte per clock while the master side takes tokens. A byte that
// makes two tokens (number then symbol) holds the next token byte in the
// input register, as the master port moves one token per cycle. Bytes pass
// the input register, then the token buffer. No clearing pass after reset.
// ----------------------------------------------------------------------------
module digit_symbol_tokenizer_core #(
    parameter int VALUE_WIDTH = 32,
    parameter int COORD_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_code
    input  logic        s_tlast,    // end_of_text

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] token_value, [47:32] column, [63:48] line
    output logic [1:0]  m_tuser,    // [1:0] token_kind
    output logic        m_tlast     // last_of_run
);

    // Input register: one byte waiting for the scanner
    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;
    logic       eot_reg;

    dst_pkg::scan_result_t scan_res;
    dst_pkg::token_t       head;
    logic                  can_load;
    logic                  consume;

    // Bytes that make no token never wait on the master side
    assign consume  = in_valid_reg && ((scan_res.count == 2'd0) || can_load);
    assign s_tready = !in_valid_reg || consume;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
            eot_reg  <= s_tlast;
        end
    end

    dst_scan #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (consume),
        .char_code   (char_reg),
        .end_of_text (eot_reg),
        .result      (scan_res)
    );

    dst_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (consume),
        .result   (scan_res),
        .ready    (m_tready),
        .valid    (m_tvalid),
        .head     (head),
        .can_load (can_load)
    );

    assign m_tdata = {head.line, head.column, head.value};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !consume) |=> (in_valid_reg && $stable(char_reg) && $stable(eot_reg)))
        else $error("pending byte lost before scanning");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && scan_res.count != 2'd0) |-> !consume)
        else $error("byte scanned while its tokens cannot be buffered");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == dst_pkg::KIND_NUMBER || m_tuser == dst_pkg::KIND_SYMBOL
                      || m_tuser == dst_pkg::KIND_ERROR))
        else $error("undefined token kind presented");

endmodule
